// ===== design/ftc_pkg.sv =====
// ----------------------------------------------------------------------------
// ftc_pkg: shared types and constants of the footprint traversability check
// Holds the Q1.15 constants, the configuration register indexes, the
// configuration and status structures, and the saturation helper.
// ----------------------------------------------------------------------------
package ftc_pkg;

    // Q1.15 word width and the value 1.0.
    localparam int Q15_W = 16;
    localparam logic [Q15_W-1:0] ONE_Q15 = 16'h8000;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WEIGHT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_WEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_VALUE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_THRESHOLD = 3'd5;

    // Configuration as used by the datapath; unsigned values already saturated.
    typedef struct packed {
        logic                    check_enable;
        logic [Q15_W-1:0]        accept_threshold;
        logic [Q15_W-1:0]        min_weight;
        logic [Q15_W-1:0]        mean_weight;
        logic [Q15_W-1:0]        unknown_value;
        logic signed [Q15_W:0]   reject_threshold;
    } ftc_cfg_t;

    // Footprint status flags kept by the accumulator.
    typedef struct packed {
        logic rejected;
        logic overflowed;
    } ftc_flags_t;

    // One result word.
    typedef struct packed {
        logic accessible;
        logic early_reject;
        logic too_many;
    } ftc_result_t;

    // Clamp a Q1.15 value to 1.0.
    function automatic logic [Q15_W-1:0] sat_q15(input logic [Q15_W-1:0] v);
        sat_q15 = (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

endpackage

// ===== design/ftc_if.sv =====
// ----------------------------------------------------------------------------
// ftc_if: channel interfaces of the footprint traversability check
// Sample channel, result channel and configuration write channel, each with
// a valid/ready handshake and its payload.
// ----------------------------------------------------------------------------
interface ftc_sample_if;
    logic                     valid;
    logic                     ready;
    logic [ftc_pkg::Q15_W-1:0] sample_value;
    logic                     known;
    logic                     last;
    logic                     func;

    modport source (output valid, output sample_value, output known, output last,
                    output func, input ready);
    modport sink   (input valid, input sample_value, input known, input last,
                    input func, output ready);
endinterface

interface ftc_result_if;
    logic valid;
    logic ready;
    logic accessible;
    logic early_reject;
    logic too_many;

    modport source (output valid, output accessible, output early_reject,
                    output too_many, input ready);
    modport sink   (input valid, input accessible, input early_reject,
                    input too_many, output ready);
endinterface

interface ftc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ftc_pkg::CFG_IDX_W-1:0]  index;
    logic [ftc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/footprint_traversability_check.sv =====
// ----------------------------------------------------------------------------
// footprint_traversability_check: footprint traversability check, top level
// Collects Q1.15 traversability samples of one footprint and scores the
// footprint on its last sample; also answers single-point checks.
//
//   Channel    Dir  Word                                     Handshake
//   sample_ch  in   sample_value, known, last, func           valid/ready
//   result_ch  out  accessible, early_reject, too_many        valid/ready
//   cfg_ch     in   index, data                               valid/ready
//
// A point check or a non-last area sample does not start the score. A last area
// sample holds off the next word until the score is through: its own accepting
// cycle, four steps through the single shared multiplier, one compare, and the
// handoff to the result register, which waits for a free slot. Reset is
// asynchronous, active low, and needs no clearing pass. The result register lets
// a new sample in while a result waits, as long as it is taken in the same cycle;
// otherwise the input and a finished score wait for it. cfg_ch is always ready.
// ----------------------------------------------------------------------------
module footprint_traversability_check #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    ftc_sample_if.sink   sample_ch,
    ftc_result_if.source result_ch,
    ftc_cfg_if.sink      cfg_ch
);
    import ftc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = CNT_W + 15;

    ftc_cfg_t          cfg_reg, cfg_next;
    logic              out_valid_reg, out_valid_next;
    ftc_result_t       out_reg, out_next;
    logic              slot_free;
    logic              sample_fire;
    logic              area_fire;
    logic              point_fire;
    logic [Q15_W-1:0]  value_sat;
    logic [Q15_W-1:0]  point_value;
    logic              score_idle;
    logic              score_done;
    ftc_result_t       score_result;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [Q15_W-1:0]  minimum;
    ftc_flags_t        flags;

    // Handshake qualifiers.
    assign slot_free       = !out_valid_reg || result_ch.ready;
    assign sample_ch.ready = score_idle && slot_free;
    assign sample_fire     = sample_ch.valid && sample_ch.ready;
    assign area_fire       = sample_fire && !sample_ch.func;
    assign point_fire      = sample_fire && sample_ch.func;
    assign value_sat       = sat_q15(sample_ch.sample_value);
    assign point_value     = sample_ch.known ? value_sat : cfg_reg.unknown_value;
    assign cfg_ch.ready    = 1'b1;

    // Configuration registers; unsigned Q1.15 values are clamped on write.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                CFG_CHECK_ENABLE:
                    cfg_next.check_enable = cfg_ch.data[0];
                CFG_ACCEPT_THRESHOLD:
                    cfg_next.accept_threshold = sat_q15(cfg_ch.data[Q15_W-1:0]);
                CFG_MIN_WEIGHT:
                    cfg_next.min_weight = sat_q15(cfg_ch.data[Q15_W-1:0]);
                CFG_MEAN_WEIGHT:
                    cfg_next.mean_weight = sat_q15(cfg_ch.data[Q15_W-1:0]);
                CFG_UNKNOWN_VALUE:
                    cfg_next.unknown_value = sat_q15(cfg_ch.data[Q15_W-1:0]);
                CFG_REJECT_THRESHOLD:
                    cfg_next.reject_threshold = $signed(cfg_ch.data[Q15_W:0]);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.check_enable     <= 1'b1;
            cfg_reg.accept_threshold <= 16'd24576;
            cfg_reg.min_weight       <= 16'd16384;
            cfg_reg.mean_weight      <= 16'd16384;
            cfg_reg.unknown_value    <= ONE_Q15;
            cfg_reg.reject_threshold <= 17'sd16384;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Footprint accumulator.
    ftc_accum #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_accum (
        .clk              (clk),
        .rst_n            (rst_n),
        .absorb           (area_fire),
        .clear            (score_done),
        .sample_value     (value_sat),
        .known            (sample_ch.known),
        .unknown_value    (cfg_reg.unknown_value),
        .reject_threshold (cfg_reg.reject_threshold),
        .count            (count),
        .sum              (sum),
        .minimum          (minimum),
        .flags            (flags)
    );

    // Closing score over the shared multiplier.
    ftc_score #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (area_fire && sample_ch.last),
        .slot_free (slot_free),
        .cfg       (cfg_reg),
        .count     (count),
        .sum       (sum),
        .minimum   (minimum),
        .flags     (flags),
        .idle      (score_idle),
        .done      (score_done),
        .result    (score_result)
    );

    // Result register: a point check or a finished score loads it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (point_fire)
        begin
            out_valid_next          = 1'b1;
            out_next.accessible     = cfg_reg.check_enable ?
                                      (point_value >= cfg_reg.accept_threshold) : 1'b1;
            out_next.early_reject   = 1'b0;
            out_next.too_many       = 1'b0;
        end
        else if (score_done)
        begin
            out_valid_next = 1'b1;
            out_next       = score_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.accessible   = out_reg.accessible;
    assign result_ch.early_reject = out_reg.early_reject;
    assign result_ch.too_many     = out_reg.too_many;

endmodule

// ===== design/ftc_accum.sv =====
// ----------------------------------------------------------------------------
// ftc_accum: footprint accumulator
// Keeps the sample count, the value sum, the known minimum and the reject and
// overflow flags of the footprint being collected.
// ----------------------------------------------------------------------------
module ftc_accum #(
    parameter int MAX_SAMPLES = 64,
    parameter int CNT_W       = 7,
    parameter int SUM_W       = 22
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        absorb,
    input  logic                        clear,
    input  logic [ftc_pkg::Q15_W-1:0]   sample_value,
    input  logic                        known,
    input  logic [ftc_pkg::Q15_W-1:0]   unknown_value,
    input  logic signed [ftc_pkg::Q15_W:0] reject_threshold,
    output logic [CNT_W-1:0]            count,
    output logic [SUM_W-1:0]            sum,
    output logic [ftc_pkg::Q15_W-1:0]   minimum,
    output ftc_pkg::ftc_flags_t         flags
);
    import ftc_pkg::*;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [Q15_W-1:0] min_reg, min_next;
    ftc_flags_t       flags_reg, flags_next;
    logic [Q15_W-1:0] add_value;

    assign add_value = known ? sample_value : unknown_value;

    // Absorb one area sample, or return to the empty footprint.
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        flags_next = flags_reg;
        if (clear)
        begin
            count_next = '0;
            sum_next   = '0;
            min_next   = ONE_Q15;
            flags_next = '0;
        end
        else if (absorb)
        begin
            if (count_reg >= MAX_CNT)
            begin
                flags_next.overflowed = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
                sum_next   = sum_reg + SUM_W'(add_value);
                if (known && (sample_value < min_reg))
                begin
                    min_next = sample_value;
                    if ($signed({1'b0, sample_value}) < reject_threshold)
                    begin
                        flags_next.rejected = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= ONE_Q15;
            flags_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            flags_reg <= flags_next;
        end
    end

    assign count   = count_reg;
    assign sum     = sum_reg;
    assign minimum = min_reg;
    assign flags   = flags_reg;

endmodule

// ===== design/ftc_score.sv =====
// ----------------------------------------------------------------------------
// ftc_score: closing score sequencer
// Evaluates min*min_weight*count + sum*mean_weight >= threshold*count*1.0
// with one shared multiplier over four steps and one compare step that also
// needs both flags clear, and holds the result until the result slot is free.
// ----------------------------------------------------------------------------
module ftc_score #(
    parameter int CNT_W = 7,
    parameter int SUM_W = 22
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       slot_free,
    input  ftc_pkg::ftc_cfg_t          cfg,
    input  logic [CNT_W-1:0]           count,
    input  logic [SUM_W-1:0]           sum,
    input  logic [ftc_pkg::Q15_W-1:0]  minimum,
    input  ftc_pkg::ftc_flags_t        flags,
    output logic                       idle,
    output logic                       done,
    output ftc_pkg::ftc_result_t       result
);
    import ftc_pkg::*;

    // Multiplier operand widths: min*weight needs 31 bits, the sum SUM_W.
    localparam int MA_W  = (SUM_W > 31) ? SUM_W : 31;
    localparam int MB_W  = (CNT_W > Q15_W) ? CNT_W : Q15_W;
    localparam int ACC_W = CNT_W + 31;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIN_W,
        S_MIN_N,
        S_SUM_W,
        S_THR_N,
        S_CMP,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [MA_W-1:0]       tmp_reg, tmp_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    ftc_result_t           res_reg, res_next;
    logic [MA_W-1:0]       mul_a;
    logic [MB_W-1:0]       mul_b;
    logic [MA_W+MB_W-1:0]  product;
    logic [ACC_W-1:0]      rhs;
    logic                  pass;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        case (state_reg)
            S_MIN_W:
            begin
                mul_a = MA_W'(minimum);
                mul_b = MB_W'(cfg.min_weight);
            end
            S_MIN_N:
            begin
                mul_a = tmp_reg;
                mul_b = MB_W'(count);
            end
            S_SUM_W:
            begin
                mul_a = MA_W'(sum);
                mul_b = MB_W'(cfg.mean_weight);
            end
            S_THR_N:
            begin
                mul_a = MA_W'(cfg.accept_threshold);
                mul_b = MB_W'(count);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // The threshold product times 1.0 is a shift by fifteen.
    assign rhs  = ACC_W'({tmp_reg, 15'b0});
    assign pass = (acc_reg >= rhs) && !flags.rejected && !flags.overflowed;

    // Step sequencer.
    always_comb
    begin
        state_next = state_reg;
        tmp_next   = tmp_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_MIN_W;
                end
            end
            S_MIN_W:
            begin
                tmp_next   = product[MA_W-1:0];
                state_next = S_MIN_N;
            end
            S_MIN_N:
            begin
                acc_next   = product[ACC_W-1:0];
                state_next = S_SUM_W;
            end
            S_SUM_W:
            begin
                acc_next   = acc_reg + product[ACC_W-1:0];
                state_next = S_THR_N;
            end
            S_THR_N:
            begin
                tmp_next   = product[MA_W-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (cfg.check_enable)
                begin
                    res_next.accessible   = pass;
                    res_next.early_reject = flags.rejected;
                    res_next.too_many     = flags.overflowed;
                end
                else
                begin
                    res_next.accessible   = 1'b1;
                    res_next.early_reject = 1'b0;
                    res_next.too_many     = 1'b0;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, intermediate products and the held result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tmp_reg   <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tmp_reg   <= tmp_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
        end
    end

    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_DONE) && slot_free;
    assign result = res_reg;

endmodule

// ===== sim/tb_footprint_traversability_check.sv =====
// ----------------------------------------------------------------------------
// tb_footprint_traversability_check: self-checking bench of the footprint check
// Drives sample words and register writes into the block and predicts every
// verdict in step with the accepted words. Directed tests cover the point and
// footprint corner cases, register extremes, footprint capacity and output
// backpressure; a long random run follows with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_footprint_traversability_check;

    import ftc_pkg::*;

    localparam int          FP_CAPACITY  = 64;
    localparam int          ITEM_TARGET  = 1450;
    localparam int          SETTLE_CYC   = 12;
    localparam int          QUIET_LIMIT  = 3000;
    localparam int          MAX_REPORTS  = 10;
    localparam logic        FUNC_AREA    = 1'b0;
    localparam logic        FUNC_POINT   = 1'b1;

    logic clk;
    logic rst_n;

    ftc_sample_if sample_ch ();
    ftc_result_if result_ch ();
    ftc_cfg_if    cfg_ch ();

    footprint_traversability_check #(
        .MAX_SAMPLES (FP_CAPACITY)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // Mirror of the register file and of the open footprint.
    ftc_cfg_t          reg_mirror;
    int unsigned       fp_count;
    longint unsigned   fp_sum;
    logic [Q15_W-1:0]  fp_min;
    bit                fp_rejected;
    bit                fp_overflowed;

    ftc_result_t       expected_verdicts[$];
    int                mismatches;
    int                items_sent;
    bit                sender_gaps;
    bit                receiver_stalls;
    int                hold_request;

    // ------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction helpers.
    // ------------------------------------------------------------------
    function automatic logic [Q15_W-1:0] clamp_q15(input logic [Q15_W-1:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    function automatic void clear_footprint();
        fp_count      = 0;
        fp_sum        = 0;
        fp_min        = ONE_Q15;
        fp_rejected   = 1'b0;
        fp_overflowed = 1'b0;
    endfunction

    function automatic ftc_cfg_t reset_config();
        ftc_cfg_t c;
        c.check_enable     = 1'b1;
        c.accept_threshold = 16'd24576;
        c.min_weight       = 16'd16384;
        c.mean_weight      = 16'd16384;
        c.unknown_value    = ONE_Q15;
        c.reject_threshold = 17'sd16384;
        return c;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CHECK_ENABLE:     reg_mirror.check_enable     = data[0];
            CFG_ACCEPT_THRESHOLD: reg_mirror.accept_threshold = data[Q15_W-1:0];
            CFG_MIN_WEIGHT:       reg_mirror.min_weight       = data[Q15_W-1:0];
            CFG_MEAN_WEIGHT:      reg_mirror.mean_weight      = data[Q15_W-1:0];
            CFG_UNKNOWN_VALUE:    reg_mirror.unknown_value    = data[Q15_W-1:0];
            CFG_REJECT_THRESHOLD: reg_mirror.reject_threshold = data;
            default: ;
        endcase
    endfunction

    // Folds one accepted sample into the footprint; returns 1 when a verdict
    // is due and fills it in.
    function automatic bit score_sample(input logic [Q15_W-1:0] raw, input logic known,
                                        input logic last, input logic func,
                                        output ftc_result_t verdict);
        logic [Q15_W-1:0] v;
        logic [Q15_W-1:0] thr;
        logic [Q15_W-1:0] unk;
        logic [Q15_W-1:0] x;
        int               reject_bound;
        longint unsigned  n;
        longint unsigned  lhs;
        longint unsigned  rhs;
        v            = clamp_q15(raw);
        thr          = clamp_q15(reg_mirror.accept_threshold);
        unk          = clamp_q15(reg_mirror.unknown_value);
        reject_bound = int'($signed(reg_mirror.reject_threshold));
        verdict      = '0;

        // A point check answers at once and leaves the footprint alone.
        if (func == FUNC_POINT)
        begin
            x = known ? v : unk;
            verdict.accessible = reg_mirror.check_enable ? (x >= thr) : 1'b1;
            return 1'b1;
        end

        // Area sample: count it unless the footprint is already full.
        if (fp_count >= FP_CAPACITY)
        begin
            fp_overflowed = 1'b1;
        end
        else
        begin
            fp_count++;
            if (!known)
            begin
                fp_sum += unk;
            end
            else
            begin
                fp_sum += v;
                if (v < fp_min)
                begin
                    fp_min = v;
                    if (int'(fp_min) < reject_bound)
                        fp_rejected = 1'b1;
                end
            end
        end

        if (!last)
            return 1'b0;

        // Weighted score of the closed footprint, cross-multiplied by count.
        if (!reg_mirror.check_enable)
        begin
            verdict.accessible = 1'b1;
        end
        else
        begin
            n   = fp_count;
            lhs = longint'(fp_min) * longint'(clamp_q15(reg_mirror.min_weight)) * n
                + fp_sum * longint'(clamp_q15(reg_mirror.mean_weight));
            rhs = longint'(thr) * n * longint'(ONE_Q15);
            verdict.accessible   = (lhs >= rhs) && !fp_rejected && !fp_overflowed;
            verdict.early_reject = fp_rejected;
            verdict.too_many     = fp_overflowed;
        end
        clear_footprint();
        return 1'b1;
    endfunction

    function automatic void note_failure(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: tracks register writes and accepted sample words.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : predictor
        ftc_result_t verdict;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                apply_register(cfg_ch.index, cfg_ch.data);
            if (sample_ch.valid && sample_ch.ready)
            begin
                if (score_sample(sample_ch.sample_value, sample_ch.known, sample_ch.last,
                                 sample_ch.func, verdict))
                    expected_verdicts.push_back(verdict);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compares each result word with the oldest expected verdict.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_checker
        ftc_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                note_failure($sformatf("result word with none expected: acc=%0b rej=%0b many=%0b",
                                       result_ch.accessible, result_ch.early_reject,
                                       result_ch.too_many));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result_ch.accessible !== want.accessible
                    || result_ch.early_reject !== want.early_reject
                    || result_ch.too_many !== want.too_many)
                    note_failure($sformatf("expected acc=%0b rej=%0b many=%0b, got acc=%0b rej=%0b many=%0b",
                                           want.accessible, want.early_reject, want.too_many,
                                           result_ch.accessible, result_ch.early_reject,
                                           result_ch.too_many));
            end
        end
    end

    // ------------------------------------------------------------------
    // Random gap length: mostly short, now and then long.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return int'($urandom_range(1, 3));
        if (r < 95)
            return int'($urandom_range(4, 10));
        return int'($urandom_range(20, 60));
    endfunction

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus a long hold on request.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                stall_left = pick_gap();
            end
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= rst_n;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when nothing moves for too long.
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] timeout: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sample sender. Valid stays high between back-to-back words.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [Q15_W-1:0] value, input logic known,
                               input logic last, input logic func);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.sample_value <= value;
        sample_ch.known        <= known;
        sample_ch.last         <= last;
        sample_ch.func         <= func;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        items_sent++;
    endtask

    // Stops sending and waits until every verdict has come back.
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Bit above a 16-bit register, set now and then to show it is ignored.
    function automatic logic junk_bit();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic write_all(input ftc_cfg_t cfg);
        write_reg(CFG_CHECK_ENABLE,     {16'd0, cfg.check_enable});
        write_reg(CFG_ACCEPT_THRESHOLD, {junk_bit(), cfg.accept_threshold});
        write_reg(CFG_MIN_WEIGHT,       {junk_bit(), cfg.min_weight});
        write_reg(CFG_MEAN_WEIGHT,      {junk_bit(), cfg.mean_weight});
        write_reg(CFG_UNKNOWN_VALUE,    {junk_bit(), cfg.unknown_value});
        write_reg(CFG_REJECT_THRESHOLD, cfg.reject_threshold);
    endtask

    // ------------------------------------------------------------------
    // Random content.
    // ------------------------------------------------------------------
    function automatic logic [Q15_W-1:0] rand_q15();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return ONE_Q15;
        if (r < 26)
            return Q15_W'($urandom_range(0, 16'hFFFF));
        return Q15_W'($urandom_range(8192, 32768));
    endfunction

    function automatic logic rand_known();
        return ($urandom_range(0, 99) < 85);
    endfunction

    function automatic int footprint_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return int'($urandom_range(1, 8));
        if (r < 85)
            return int'($urandom_range(9, 40));
        if (r < 95)
            return int'($urandom_range(41, FP_CAPACITY));
        return int'($urandom_range(FP_CAPACITY + 1, FP_CAPACITY + 8));
    endfunction

    function automatic ftc_cfg_t random_config();
        ftc_cfg_t    c;
        int unsigned r;
        int          bound;
        c.check_enable     = ($urandom_range(0, 9) != 0);
        c.accept_threshold = rand_q15();
        c.min_weight       = rand_q15();
        c.mean_weight      = rand_q15();
        c.unknown_value    = rand_q15();
        r = $urandom_range(0, 99);
        if (r < 10)
            bound = -32768;
        else if (r < 20)
            bound = 32768;
        else if (r < 30)
            bound = 0;
        else
            bound = int'($urandom_range(0, 36864)) - 4096;
        c.reject_threshold = 17'(bound);
        return c;
    endfunction

    // One area footprint of random samples, with point checks mixed in.
    task automatic send_footprint(input int len);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(rand_q15(), rand_known(), 1'($urandom_range(0, 1)), FUNC_POINT);
            send_sample(rand_q15(), rand_known(), i == len - 1, FUNC_AREA);
        end
    endtask

    task automatic run_phase(input ftc_cfg_t cfg, input int footprints);
        wait_for_results();
        write_all(cfg);
        for (int i = 0; i < footprints; i++)
            send_footprint(int'($urandom_range(1, 4)));
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Point checks around the reset threshold of 0.75 and at the extremes.
    task automatic test_point_checks();
        send_sample(16'd24576, 1'b1, 1'b0, FUNC_POINT);
        send_sample(16'd24575, 1'b1, 1'b0, FUNC_POINT);
        send_sample(16'hFFFF,  1'b1, 1'b1, FUNC_POINT);
        send_sample(16'd0,     1'b1, 1'b0, FUNC_POINT);
        send_sample(16'd0,     1'b0, 1'b1, FUNC_POINT);
        send_sample(ONE_Q15,   1'b1, 1'b0, FUNC_POINT);
    endtask

    // Single- and multi-sample footprints under the reset settings.
    task automatic test_footprints();
        // Score exactly on the threshold, then one step below it.
        send_sample(16'd24576, 1'b1, 1'b1, FUNC_AREA);
        send_sample(16'd24575, 1'b1, 1'b1, FUNC_AREA);
        // Minimum below the reject bound.
        send_sample(16'd16383, 1'b1, 1'b1, FUNC_AREA);
        // Unknown sample only.
        send_sample(16'd0,     1'b0, 1'b1, FUNC_AREA);
        // Value above 1.0, an unknown sample, and a minimum right at the bound.
        send_sample(16'hFFFF,  1'b1, 1'b0, FUNC_AREA);
        send_sample(16'd20000, 1'b0, 1'b0, FUNC_AREA);
        send_sample(16'd16384, 1'b1, 1'b1, FUNC_AREA);
        // A point check in the middle leaves the footprint untouched.
        send_sample(16'd30000, 1'b1, 1'b0, FUNC_AREA);
        send_sample(16'd10000, 1'b1, 1'b0, FUNC_POINT);
        send_sample(16'd28000, 1'b1, 1'b1, FUNC_AREA);
    endtask

    // Register extremes, each followed by a few short footprints.
    task automatic test_register_extremes();
        ftc_cfg_t cfg;
        // Check disabled: always accessible, even with a rejecting sample.
        cfg = reset_config();
        cfg.check_enable = 1'b0;
        wait_for_results();
        write_all(cfg);
        send_sample(16'd0, 1'b1, 1'b0, FUNC_AREA);
        send_sample(16'd0, 1'b1, 1'b1, FUNC_AREA);
        send_sample(16'd0, 1'b1, 1'b0, FUNC_POINT);
        // All zero; reject bound at -1.0.
        cfg = '0;
        cfg.check_enable     = 1'b1;
        cfg.reject_threshold = -17'sd32768;
        run_phase(cfg, 3);
        // Everything at 1.0, the reject bound too.
        cfg.accept_threshold = ONE_Q15;
        cfg.min_weight       = ONE_Q15;
        cfg.mean_weight      = ONE_Q15;
        cfg.unknown_value    = ONE_Q15;
        cfg.reject_threshold = 17'sd32768;
        run_phase(cfg, 3);
        // Values above 1.0 saturate; no unknown credit.
        cfg.accept_threshold = 16'hFFFF;
        cfg.min_weight       = 16'hFFFF;
        cfg.mean_weight      = 16'd0;
        cfg.unknown_value    = 16'd0;
        cfg.reject_threshold = 17'sd0;
        run_phase(cfg, 3);
        cfg.accept_threshold = 16'd0;
        cfg.min_weight       = 16'd0;
        cfg.mean_weight      = ONE_Q15;
        cfg.unknown_value    = 16'hFFFF;
        cfg.reject_threshold = -17'sd1;
        run_phase(cfg, 3);
        run_phase(reset_config(), 0);
    endtask

    // Footprints at capacity and beyond it.
    task automatic test_capacity();
        sender_gaps = 1'b0;
        send_footprint(FP_CAPACITY);
        send_footprint(FP_CAPACITY + 1);
        sender_gaps = 1'b1;
        send_footprint(FP_CAPACITY + 6);
        // Past capacity a low sample must not count toward the minimum.
        for (int i = 0; i < FP_CAPACITY; i++)
            send_sample(ONE_Q15, 1'b1, 1'b0, FUNC_AREA);
        send_sample(16'd0, 1'b1, 1'b1, FUNC_AREA);
    endtask

    // Long output hold while words keep coming; then a full drain.
    task automatic test_backpressure();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        hold_request    = 250;
        @(posedge clk);
        @(posedge clk);
        for (int i = 0; i < 30; i++)
            send_sample(rand_q15(), rand_known(), 1'($urandom_range(0, 1)), FUNC_POINT);
        send_footprint(5);
        send_footprint(1);
        wait_for_results();
        receiver_stalls = 1'b1;
        sender_gaps     = 1'b1;
    endtask

    // Random traffic across several register settings.
    task automatic test_random_traffic();
        int phase_end;
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_for_results();
            write_all(random_config());
            sender_gaps     = (phase % 3 != 0);
            receiver_stalls = (phase % 2 == 1);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (6 - phase);
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    sender_gaps     = ~sender_gaps;
                    receiver_stalls = ~receiver_stalls;
                end
                if ($urandom_range(0, 99) < 15)
                    send_sample(rand_q15(), rand_known(), 1'($urandom_range(0, 1)),
                                FUNC_POINT);
                else
                    send_footprint(footprint_length());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n                  <= 1'b0;
        sample_ch.valid        <= 1'b0;
        sample_ch.sample_value <= '0;
        sample_ch.known        <= 1'b0;
        sample_ch.last         <= 1'b0;
        sample_ch.func         <= FUNC_AREA;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= CFG_CHECK_ENABLE;
        cfg_ch.data            <= '0;
        reg_mirror       = reset_config();
        clear_footprint();
        mismatches       = 0;
        items_sent       = 0;
        sender_gaps      = 1'b1;
        receiver_stalls  = 1'b1;
        hold_request     = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_point_checks();
        test_footprints();
        test_register_extremes();
        test_capacity();
        test_backpressure();
        test_random_traffic();
        wait_for_results();

        if (expected_verdicts.size() != 0)
            note_failure("verdicts still outstanding at end of run");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ftc_pkg.sv
design/ftc_if.sv
design/ftc_accum.sv
design/ftc_score.sv
design/footprint_traversability_check.sv
sim/tb_footprint_traversability_check.sv
